// ===== rtl/core/sms_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SPI master byte shifter package
// Shared types, register indexes and constants of the byte shifter.
// ----------------------------------------------------------------------------
package sms_pkg;

   localparam int unsigned NumBits  = 8;
   localparam int unsigned BitCntW  = $clog2(NumBits);
   localparam int unsigned CsrIdxW  = 2;
   localparam int unsigned CsrDataW = 8;

   localparam logic [BitCntW-1:0] LastBit = BitCntW'(NumBits - 1);

   typedef enum logic [CsrIdxW-1:0] {
      CSR_SPI_MODE    = 2'd0,
      CSR_LSB_LEAD    = 2'd1,
      CSR_HALF_PERIOD = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic [1:0] spi_mode;
      logic       lsb_lead;
      logic [7:0] half_period;
   } cfg_type;

   typedef struct packed {
      logic       start_req;
      logic [7:0] tx_byte;
      logic       miso;
   } item_type;

   typedef struct packed {
      logic       sck;
      logic       mosi;
      logic       busy_res;
      logic       done_res;
      logic [7:0] rx_byte;
   } res_type;

endpackage

// ===== rtl/core/sms_csr.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SPI master configuration registers
// Holds clock mode, bit order and half period, written through the CSR port.
// ----------------------------------------------------------------------------
module sms_csr
   import sms_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_we,
   input  logic [CsrIdxW-1:0]  csr_index,
   input  logic [CsrDataW-1:0] csr_wdata,
   output cfg_type             cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_SPI_MODE:    cfg_in.spi_mode    = csr_wdata[1:0];
            CSR_LSB_LEAD:    cfg_in.lsb_lead    = csr_wdata[0];
            CSR_HALF_PERIOD: cfg_in.half_period = csr_wdata[7:0];
            default:         cfg_in = cfg_ff; // drop writes outside the map
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== rtl/core/sms_in_reg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SPI master input register
// Captures one tick transaction and holds it until the engine advances.
// ----------------------------------------------------------------------------
module sms_in_reg
   import sms_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_ready,
   input  item_type req_item,
   input  logic     advance,
   output logic     item_valid,
   output item_type item
);

   logic     valid_ff;
   logic     valid_in;
   item_type item_ff;

   assign req_ready = !valid_ff || advance;

   always_comb begin
      valid_in = valid_ff;
      if (req_ready) begin
         valid_in = req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         item_ff <= req_item;
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

// ===== rtl/core/sms_engine.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SPI master shift engine
// Exchange state and the per-tick step: pin levels, bit timing and shifting.
// ----------------------------------------------------------------------------
module sms_engine
   import sms_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  cfg_type  cfg,
   input  logic     advance,
   input  item_type item,
   output res_type  res
);

   logic               active_ff,      active_in;
   logic [7:0]         tx_shift_ff,    tx_shift_in;
   logic [7:0]         rx_shift_ff,    rx_shift_in;
   logic [BitCntW-1:0] bit_count_ff,   bit_count_in;
   logic [7:0]         tick_count_ff,  tick_count_in;
   logic               second_half_ff, second_half_in;

   logic               go;
   logic               act;
   logic [7:0]         txs;
   logic [7:0]         rxs;
   logic [BitCntW-1:0] bc;
   logic [7:0]         tc;
   logic               sh;
   logic               cpol;
   logic               cpha;

   assign cpol = cfg.spi_mode[1];
   assign cpha = cfg.spi_mode[0];

   // a start while idle makes this tick the first of the exchange
   assign go  = !active_ff && item.start_req;
   assign act = active_ff || go;
   assign txs = go ? item.tx_byte : tx_shift_ff;
   assign rxs = go ? 8'd0 : rx_shift_ff;
   assign bc  = go ? '0 : bit_count_ff;
   assign tc  = go ? 8'd0 : tick_count_ff;
   assign sh  = go ? 1'b0 : second_half_ff;

   always_comb begin
      active_in      = act;
      tx_shift_in    = txs;
      rx_shift_in    = rxs;
      bit_count_in   = bc;
      tick_count_in  = tc;
      second_half_in = sh;
      res            = '0;
      res.sck        = cpol;
      if (act) begin
         res.busy_res = 1'b1;
         res.sck      = cpol ^ cpha ^ sh;
         res.mosi     = cfg.lsb_lead ? txs[0] : txs[7];
         if (tc >= cfg.half_period) begin
            tick_count_in = 8'd0;
            if (!sh) begin
               // sample MISO at the end of the first half
               rx_shift_in    = cfg.lsb_lead ? {item.miso, rxs[7:1]} : {rxs[6:0], item.miso};
               second_half_in = 1'b1;
            end else begin
               second_half_in = 1'b0;
               tx_shift_in    = cfg.lsb_lead ? {1'b0, txs[7:1]} : {txs[6:0], 1'b0};
               if (bc == LastBit) begin
                  res.done_res = 1'b1;
                  res.rx_byte  = rxs;
                  active_in    = 1'b0;
                  bit_count_in = '0;
               end else begin
                  bit_count_in = bc + 1'b1;
               end
            end
         end else begin
            tick_count_in = tc + 8'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff      <= 1'b0;
         tx_shift_ff    <= '0;
         rx_shift_ff    <= '0;
         bit_count_ff   <= '0;
         tick_count_ff  <= '0;
         second_half_ff <= 1'b0;
      end else if (advance) begin
         active_ff      <= active_in;
         tx_shift_ff    <= tx_shift_in;
         rx_shift_ff    <= rx_shift_in;
         bit_count_ff   <= bit_count_in;
         tick_count_ff  <= tick_count_in;
         second_half_ff <= second_half_in;
      end
   end

   a_idle_clear: assert property (@(posedge clock) disable iff (reset)
      !active_ff |-> (tick_count_ff == 8'd0) && !second_half_ff && (bit_count_ff == '0))
      else $error("idle engine holds stale timing state");

   a_done_busy: assert property (@(posedge clock) disable iff (reset)
      (advance && res.done_res) |-> res.busy_res)
      else $error("done reported outside an exchange");

   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      (advance && res.done_res) |=> !active_ff)
      else $error("engine still active after done");

endmodule

// ===== rtl/core/spi_master_byte_shifter.sv =====
`timescale 1ns / 1ps
// Path: a tick transaction passes the input register, then the engine step into
//   the result register, where its result is held until taken with rsp_ready.
// Throughput: one tick transaction per cycle; a waiting result stalls the
//   engine, and the input register takes at most one more transaction.
// Reset: synchronous, active high; clears exchange state and config to zero.
// ----------------------------------------------------------------------------
// SPI master byte shifter
// Top level: CSR block, input register, shift engine and result register.
// ----------------------------------------------------------------------------
module spi_master_byte_shifter
   import sms_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic                req_start_req,
   input  logic [7:0]          req_tx_byte,
   input  logic                req_miso,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic                rsp_sck,
   output logic                rsp_mosi,
   output logic                rsp_busy_res,
   output logic                rsp_done_res,
   output logic [7:0]          rsp_rx_byte,
   input  logic                csr_we,
   input  logic [CsrIdxW-1:0]  csr_index,
   input  logic [CsrDataW-1:0] csr_wdata
);

   cfg_type  cfg;
   item_type req_item;
   item_type item;
   logic     item_valid;
   logic     advance;
   res_type  res;
   res_type  out_ff;
   logic     out_valid_ff;
   logic     out_valid_in;

   assign req_item.start_req = req_start_req;
   assign req_item.tx_byte   = req_tx_byte;
   assign req_item.miso      = req_miso;

   // advance when the result register is free or being emptied
   assign advance = item_valid && (!out_valid_ff || rsp_ready);

   sms_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   sms_in_reg u_in_reg (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_item   (req_item),
      .advance    (advance),
      .item_valid (item_valid),
      .item       (item)
   );

   sms_engine u_engine (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg),
      .advance (advance),
      .item    (item),
      .res     (res)
   );

   always_comb begin
      out_valid_in = out_valid_ff && !rsp_ready;
      if (advance) begin
         out_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_ff <= res;
      end
   end

   assign rsp_valid    = out_valid_ff;
   assign rsp_sck      = out_ff.sck;
   assign rsp_mosi     = out_ff.mosi;
   assign rsp_busy_res = out_ff.busy_res;
   assign rsp_done_res = out_ff.done_res;
   assign rsp_rx_byte  = out_ff.rx_byte;

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SPI master byte shifter testbench
// Drives one tick transaction per item through the request channel and
// checks every result against an in-bench model of the shift engine: SCK and
// MOSI levels, busy, done and the received byte. Directed tests cover idle
// levels, starts while busy, back to back exchanges and a half period cut
// short by a register change. Random phases then sweep all modes, both bit
// orders and a range of half periods, with random idling on both channels.
// ----------------------------------------------------------------------------
module tb;
   import sms_pkg::*;

   localparam int unsigned CycleLimit = 1000000;
   localparam int unsigned RandomTicks = 1000;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_ready;
   logic                req_start_req = 1'b0;
   logic [7:0]          req_tx_byte = 8'h00;
   logic                req_miso = 1'b0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   logic                rsp_sck;
   logic                rsp_mosi;
   logic                rsp_busy_res;
   logic                rsp_done_res;
   logic [7:0]          rsp_rx_byte;
   logic                csr_we = 1'b0;
   csr_index_type       csr_index = CSR_SPI_MODE;
   logic [CsrDataW-1:0] csr_wdata = '0;

   // register copies and shift engine state of the model
   logic [1:0] cfg_mode = 2'd0;
   logic       cfg_lsb = 1'b0;
   logic [7:0] cfg_half = 8'd0;
   logic       eng_active = 1'b0;
   logic [7:0] eng_tx = 8'd0;
   logic [7:0] eng_rx = 8'd0;
   logic [3:0] eng_bit = 4'd0;
   logic [7:0] eng_tick = 8'd0;
   logic       eng_second = 1'b0;
   logic       eng_sck = 1'b0;

   res_type     expected_ticks[$];
   int unsigned mismatches = 0;
   int unsigned ticks_sent = 0;
   int unsigned cycle_count = 0;
   int unsigned rsp_stall = 0;
   logic        no_idle = 1'b0;

   spi_master_byte_shifter dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_start_req (req_start_req),
      .req_tx_byte   (req_tx_byte),
      .req_miso      (req_miso),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_sck       (rsp_sck),
      .rsp_mosi      (rsp_mosi),
      .rsp_busy_res  (rsp_busy_res),
      .rsp_done_res  (rsp_done_res),
      .rsp_rx_byte   (rsp_rx_byte),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CycleLimit) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   function automatic int unsigned draw_wait();
      if (no_idle) begin
         return 0;
      end
      return $urandom_range(0, 15);
   endfunction

   // Advance the shift engine by one tick and return the pin levels it gives.
   function automatic res_type shifter_tick(logic start, logic [7:0] txb, logic miso_in);
      res_type r;
      logic    cpol;
      logic    cpha;
      cpol = cfg_mode[1];
      cpha = cfg_mode[0];
      r = '0;
      if (!eng_active && start) begin
         eng_active = 1'b1;
         eng_tx = txb;
         eng_rx = 8'd0;
         eng_bit = 4'd0;
         eng_tick = 8'd0;
         eng_second = 1'b0;
      end
      if (eng_active) begin
         r.busy_res = 1'b1;
         eng_sck = cpol ^ cpha ^ eng_second;
         r.mosi = cfg_lsb ? eng_tx[0] : eng_tx[7];
         if (eng_tick >= cfg_half) begin
            eng_tick = 8'd0;
            if (!eng_second) begin
               // sample MISO at the end of the first half
               eng_rx = cfg_lsb ? {miso_in, eng_rx[7:1]} : {eng_rx[6:0], miso_in};
               eng_second = 1'b1;
            end else begin
               eng_second = 1'b0;
               eng_tx = cfg_lsb ? (eng_tx >> 1) : (eng_tx << 1);
               if (eng_bit >= LastBit) begin
                  r.done_res = 1'b1;
                  r.rx_byte = eng_rx;
                  eng_active = 1'b0;
                  eng_bit = 4'd0;
               end else begin
                  eng_bit = eng_bit + 4'd1;
               end
            end
         end else begin
            eng_tick = eng_tick + 8'd1;
         end
      end else begin
         eng_sck = cpol;
      end
      r.sck = eng_sck;
      return r;
   endfunction

   // Send one tick transaction; hold valid until it is taken.
   task automatic send_tick(input logic start, input logic [7:0] txb, input logic miso_in);
      int unsigned gap;
      gap = draw_wait();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_start_req <= start;
      req_tx_byte <= txb;
      req_miso <= miso_in;
      do @(posedge clock); while (!req_ready);
      expected_ticks.push_back(shifter_tick(start, txb, miso_in));
      ticks_sent++;
   endtask

   // Drop valid and wait until every result is back and the pipeline is empty.
   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_ticks.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic set_config(input logic [1:0] mode, input logic lsb, input logic [7:0] half);
      wait_idle();
      csr_we <= 1'b1;
      csr_index <= CSR_SPI_MODE;
      csr_wdata <= CsrDataW'(mode);
      @(posedge clock);
      csr_index <= CSR_LSB_LEAD;
      csr_wdata <= CsrDataW'(lsb);
      @(posedge clock);
      csr_index <= CSR_HALF_PERIOD;
      csr_wdata <= CsrDataW'(half);
      @(posedge clock);
      csr_we <= 1'b0;
      cfg_mode = mode;
      cfg_lsb = lsb;
      cfg_half = half;
   endtask

   task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
      if (got !== want) begin
         $error("%s mismatch: expected %0h, got %0h", name, want, got);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin
      res_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_ticks.size() == 0) begin
            $error("result transaction with no tick pending");
            mismatches++;
         end else begin
            want = expected_ticks.pop_front();
            check_field("sck", 8'(want.sck), 8'(rsp_sck));
            check_field("mosi", 8'(want.mosi), 8'(rsp_mosi));
            check_field("busy_res", 8'(want.busy_res), 8'(rsp_busy_res));
            check_field("done_res", 8'(want.done_res), 8'(rsp_done_res));
            check_field("rx_byte", want.rx_byte, rsp_rx_byte);
         end
         rsp_stall = draw_wait();
      end else if (rsp_stall > 0) begin
         rsp_stall--;
      end
      rsp_ready <= (rsp_stall == 0);
   end

   task automatic test_idle_levels();
      set_config(2'd2, 1'b0, 8'd0);
      send_tick(1'b0, 8'hFF, 1'b1);
      send_tick(1'b0, 8'h00, 1'b0);
   endtask

   // Start held high through a whole exchange, then a new one on the next tick.
   task automatic test_busy_start_and_back_to_back();
      set_config(2'd0, 1'b0, 8'd0);
      for (int i = 0; i < 16; i++) begin
         send_tick(1'b1, (i == 0) ? 8'hFF : 8'($urandom_range(0, 255)), 1'b1);
      end
      for (int i = 0; i < 16; i++) begin
         send_tick(i == 0, (i == 0) ? 8'h00 : 8'($urandom_range(0, 255)), 1'b0);
      end
   endtask

   // Half period lowered below the tick count already reached mid-exchange.
   task automatic test_half_period_cut();
      set_config(2'd1, 1'b1, 8'd3);
      send_tick(1'b1, 8'hA5, 1'b1);
      send_tick(1'b0, 8'h00, 1'b0);
      send_tick(1'b0, 8'h00, 1'b1);
      set_config(2'd1, 1'b1, 8'd0);
      for (int i = 0; i < 16; i++) begin
         send_tick(1'b0, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      end
   endtask

   task automatic test_random_phases();
      int unsigned first_tick;
      int unsigned pick;
      int unsigned span;
      logic [7:0]  half;
      first_tick = ticks_sent;
      while (ticks_sent - first_tick < RandomTicks) begin
         pick = $urandom_range(0, 9);
         if (pick < 6) begin
            half = 8'($urandom_range(0, 2));
         end else begin
            half = 8'($urandom_range(3, 10));
         end
         set_config(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)), half);
         no_idle = ($urandom_range(0, 3) == 0);
         repeat ($urandom_range(1, 4)) begin
            // a little noise with no start between exchanges
            repeat ($urandom_range(0, 3)) begin
               send_tick(1'b0, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
            end
            span = 16 * (int'(half) + 1);
            if ($urandom_range(0, 7) == 0) begin
               span = $urandom_range(1, span - 1);
            end
            send_tick(1'b1, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
            for (int i = 1; i < span; i++) begin
               send_tick($urandom_range(0, 7) == 0, 8'($urandom_range(0, 255)),
                         1'($urandom_range(0, 1)));
            end
         end
         no_idle = 1'b0;
      end
   endtask

   // First bit time of an exchange at the longest half period, without idling.
   task automatic test_slowest_clock();
      set_config(2'd3, 1'b1, 8'd255);
      no_idle = 1'b1;
      send_tick(1'b1, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      for (int i = 1; i < 2 * 256 + 8; i++) begin
         send_tick($urandom_range(0, 7) == 0, 8'($urandom_range(0, 255)),
                   1'($urandom_range(0, 1)));
      end
      no_idle = 1'b0;
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      test_idle_levels();
      test_busy_start_and_back_to_back();
      test_half_period_cut();
      test_random_phases();
      test_slowest_clock();
      wait_idle();
      repeat (4) @(posedge clock);
      if (mismatches == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
